// File: design/hfr_pkg.sv
// hfr_pkg: shared types, constants and the keyword table for the HTTP request framer.
// No dependencies. Used by hfr_len_parse, hfr_frame_ctl and http_request_framer.
`default_nettype none

package hfr_pkg;

    // default width of the Content-Length value and the body counter
    localparam int LEN_WIDTH_DEF  = 32;
    localparam int KEYWORD_LEN    = 15;
    localparam int TERMINATOR_LEN = 4;
    localparam int KW_IDX_W       = 4;
    localparam int TERM_W         = 2;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;

    // value parser phase
    typedef enum logic [2:0] {
        VP_SEARCH = 3'd0,
        VP_BLANK  = 3'd1,
        VP_SIGN   = 3'd2,
        VP_DIGITS = 3'd3,
        VP_CLOSED = 3'd4
    } value_phase_t;

    // per-beat marks from the frame controller
    typedef struct packed {
        logic is_body;
        logic header_done;
        logic request_last;
    } beat_flags_t;

    // "content-length:" in lower case
    function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/hfr_len_parse.sv
// hfr_len_parse: finds the first case-insensitive "content-length:" in the header
// and accumulates the decimal value after it. Depends on hfr_pkg.
`default_nettype none

module hfr_len_parse #(
    parameter int LEN_WIDTH = hfr_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 clear,
    input  wire logic [7:0]           data_byte,
    output logic      [LEN_WIDTH-1:0] length_eff
);
    import hfr_pkg::*;

    localparam int PW = LEN_WIDTH + 4;

    logic [KW_IDX_W-1:0]  kw_reg, kw_next;
    value_phase_t         phase_reg, phase_next;
    logic [LEN_WIDTH-1:0] value_reg, value_next;
    logic                 ovf_reg, ovf_next;

    logic [7:0]           lc;
    logic [KW_IDX_W-1:0]  k;
    logic                 is_digit;
    logic [PW-1:0]        v_ext;
    logic [PW-1:0]        prod;
    logic                 prod_ovf;

    // lower-case fold and digit accumulate (value*10 + digit, overflow if it leaves LEN_WIDTH)
    assign lc       = (data_byte >= CHAR_UC_A && data_byte <= CHAR_UC_Z) ?
                      (data_byte + 8'd32) : data_byte;
    assign k        = (kw_reg >= KW_IDX_W'(KEYWORD_LEN)) ? '0 : kw_reg;
    assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    assign v_ext    = {4'b0000, value_reg};
    assign prod     = (v_ext << 3) + (v_ext << 1) + PW'(data_byte - CHAR_ZERO);
    assign prod_ovf = |prod[PW-1:LEN_WIDTH];

    // next state for one header byte
    always_comb
    begin
        kw_next    = kw_reg;
        phase_next = phase_reg;
        value_next = value_reg;
        ovf_next   = ovf_reg;
        case (phase_reg)
            VP_SEARCH:
            begin
                if (lc == kw_char(k)) begin
                    if (k == KW_IDX_W'(KEYWORD_LEN - 1)) begin
                        kw_next    = '0;
                        phase_next = VP_BLANK;
                    end else begin
                        kw_next = k + 1'b1;
                    end
                end else begin
                    kw_next = (lc == kw_char('0)) ? KW_IDX_W'(1) : '0;
                end
            end
            VP_BLANK:
            begin
                if (data_byte == CHAR_SPACE || data_byte == CHAR_TAB) begin
                    phase_next = VP_BLANK;
                end else if (data_byte == CHAR_PLUS) begin
                    phase_next = VP_SIGN;
                end else if (data_byte == CHAR_MINUS) begin
                    value_next = '0;
                    ovf_next   = 1'b0;
                    phase_next = VP_CLOSED;
                end else if (is_digit) begin
                    phase_next = VP_DIGITS;
                    if (!ovf_reg) begin
                        ovf_next   = prod_ovf;
                        value_next = prod_ovf ? '0 : prod[LEN_WIDTH-1:0];
                    end
                end else begin
                    phase_next = VP_CLOSED;
                end
            end
            VP_SIGN, VP_DIGITS:
            begin
                if (is_digit) begin
                    phase_next = VP_DIGITS;
                    if (!ovf_reg) begin
                        ovf_next   = prod_ovf;
                        value_next = prod_ovf ? '0 : prod[LEN_WIDTH-1:0];
                    end
                end else begin
                    phase_next = VP_CLOSED;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // length as seen after this byte; zero without keyword or on overflow
    assign length_eff = (phase_next == VP_SEARCH || ovf_next) ? '0 : value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kw_reg    <= '0;
            phase_reg <= VP_SEARCH;
            value_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (clear) begin
            kw_reg    <= '0;
            phase_reg <= VP_SEARCH;
            value_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (step) begin
            kw_reg    <= kw_next;
            phase_reg <= phase_next;
            value_reg <= value_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// File: design/hfr_frame_ctl.sv
// hfr_frame_ctl: CR LF CR LF detection, body byte counting and per-beat marks.
// Depends on hfr_pkg.
`default_nettype none

module hfr_frame_ctl #(
    parameter int LEN_WIDTH = hfr_pkg::LEN_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [7:0]                   data_byte,
    input  wire logic [LEN_WIDTH-1:0]         length_eff,
    output logic                              in_body,
    output logic                              clear,
    output hfr_pkg::beat_flags_t              flags
);
    import hfr_pkg::*;

    logic                 body_reg, body_next;
    logic [TERM_W-1:0]    term_reg, term_next;
    logic [LEN_WIDTH-1:0] remain_reg, remain_next;

    logic [TERM_W:0]      t;
    logic [7:0]           want;
    logic [LEN_WIDTH-1:0] remain_dec;

    assign in_body    = body_reg;
    assign want       = term_reg[0] ? CHAR_LF : CHAR_CR;
    assign remain_dec = remain_reg - 1'b1;

    // terminator match and body countdown
    always_comb
    begin
        body_next   = body_reg;
        term_next   = term_reg;
        remain_next = remain_reg;
        clear       = 1'b0;
        flags       = '0;
        t           = '0;
        if (body_reg) begin
            flags.is_body = 1'b1;
            remain_next   = remain_dec;
            if (remain_dec == '0) begin
                flags.request_last = 1'b1;
                clear              = accept;
                body_next          = 1'b0;
            end
        end else begin
            if (data_byte == want) begin
                t = {1'b0, term_reg} + 1'b1;
            end else begin
                t = (data_byte == CHAR_CR) ? (TERM_W+1)'(1) : '0;
            end
            term_next = t[TERM_W-1:0];
            if (t == (TERM_W+1)'(TERMINATOR_LEN)) begin
                flags.header_done = 1'b1;
                clear             = accept;
                term_next         = '0;
                if (length_eff == '0) begin
                    flags.request_last = 1'b1;
                    remain_next        = '0;
                end else begin
                    body_next   = 1'b1;
                    remain_next = length_eff;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            body_reg   <= 1'b0;
            term_reg   <= '0;
            remain_reg <= '0;
        end else if (accept) begin
            body_reg   <= body_next;
            term_reg   <= term_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

// File: design/http_request_framer.sv
// http_request_framer: top level; byte channel in, marked byte channel out.
// Depends on hfr_pkg, hfr_len_parse, hfr_frame_ctl.
//
// Usage:
//   Input channel: data_byte with in_valid / in_ready. One request byte per beat.
//   Output channel: out_byte, is_body, header_done, request_last with
//   out_valid / out_ready. Exactly one output beat per input beat, in order.
//   Each byte is echoed; is_body marks body bytes, header_done marks the LF
//   that ends the header, request_last marks the final byte of a request.
//   The body length comes from the first "content-length:" in the header;
//   missing, empty, negative or oversized values give an empty body.
//   Output register: an accepted byte appears on the output in the next cycle.
//   Throughput: one byte per cycle while out_ready is high, set by the single output register;
//   in_ready stays high while that register is empty or being drained.
//   Stall: with out_ready low the output beat holds and in_ready drops
//   until it is taken.
//   Reset: rst_n clears all framing state and out_valid, but not the output
//   byte or marks; the block starts in the header of a new request, ready at once.
`default_nettype none

module http_request_framer #(
    parameter int LEN_WIDTH = hfr_pkg::LEN_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic [7:0]      out_byte,
    output logic            is_body,
    output logic            header_done,
    output logic            request_last,
    output logic            out_valid,
    input  wire logic       out_ready
);
    import hfr_pkg::*;

    logic                 accept;
    logic                 in_body;
    logic                 clear;
    logic [LEN_WIDTH-1:0] length_eff;
    beat_flags_t          flags;

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    beat_flags_t          flags_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    hfr_len_parse #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_len_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept && !in_body),
        .clear      (clear),
        .data_byte  (data_byte),
        .length_eff (length_eff)
    );

    hfr_frame_ctl #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_frame_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (data_byte),
        .length_eff (length_eff),
        .in_body    (in_body),
        .clear      (clear),
        .flags      (flags)
    );

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept) begin
            out_byte_reg <= data_byte;
            flags_reg    <= flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_body      = flags_reg.is_body;
    assign header_done  = flags_reg.header_done;
    assign request_last = flags_reg.request_last;

endmodule

`default_nettype wire

// File: design/hfr_checker.sv
// hfr_checker: port-level assertions for http_request_framer, and its bind.
// Depends only on the top level's ports.
`default_nettype none

module hfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic [7:0] data_byte,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] out_byte,
    input wire logic       is_body,
    input wire logic       header_done,
    input wire logic       request_last,
    input wire logic       out_valid,
    input wire logic       out_ready
);

    // a stalled output beat holds its byte
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output beat changed while stalled");

    // every accepted byte shows up on the next cycle, unchanged
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid && out_byte == $past(data_byte))
        else $error("accepted byte not echoed next cycle");

    // header end is always an LF and never a body byte
    a_hdr_lf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && header_done |-> out_byte == 8'h0A && !is_body)
        else $error("header_done on wrong byte");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a header byte that is not the header end cannot finish a request
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_last && !is_body |-> header_done)
        else $error("request_last on a plain header byte");

endmodule

bind http_request_framer hfr_checker u_hfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .data_byte    (data_byte),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_byte     (out_byte),
    .is_body      (is_body),
    .header_done  (header_done),
    .request_last (request_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
);

`default_nettype wire
